// ===== design/efd_pkg.sv =====
// Package with word types, frame constants and the bytewise CRC-32 step.
package efd_pkg;

    localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;
    localparam logic [31:0] CRC_ALL  = 32'hFFFF_FFFF;
    localparam logic [7:0]  PRE_BYTE = 8'hAA;
    localparam logic [7:0]  SFD_BYTE = 8'hAB;
    localparam logic [4:0]  HDR_LEN  = 5'd18;
    localparam logic [2:0]  PRE_MIN  = 3'd7;
    localparam logic [15:0] BODY_MAX = 16'hFFFF;

    typedef enum logic [1:0] {
        STATUS_OK       = 2'd0,
        STATUS_CRC_BAD  = 2'd1,
        STATUS_RUNT     = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        ST_HUNT  = 2'b01,
        ST_FRAME = 2'b10
    } state_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       frame_end;
    } in_word_t;

    typedef struct packed {
        logic [47:0] dest_address;
        logic [47:0] source_address;
        logic [15:0] ether_type;
        logic [15:0] payload_length;
        logic [31:0] received_fcs;
        logic [31:0] computed_crc;
        logic [7:0]  frame_number;
        logic [1:0]  status;
    } out_word_t;

    function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
        logic [31:0] c;
        c = {24'd0, crc[7:0] ^ b};
        for (int k = 0; k < 8; k++) begin
            c = c[0] ? (CRC_POLY ^ (c >> 1)) : (c >> 1);
        end
        return c ^ (crc >> 8);
    endfunction

endpackage

// ===== design/ethernet_frame_deframer_fcs.sv =====
// Top level of the Ethernet deframer: input register, frame core and result register.
// A result is registered when the core steps on the frame's end byte held in the input register.
// Throughput: one byte word per cycle unless a result waits; the bytewise CRC is combinational.
// While a result waits unaccepted the core holds and the input register takes one more word.
// Reset (aresetn low, synchronous) empties both registers, restarts the preamble hunt
// and clears the frame counter.
module ethernet_frame_deframer_fcs
    import efd_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  in_word_t  s_data,
    output logic      m_valid,
    input  logic      m_ready,
    output out_word_t m_data
);

    logic      in_valid_reg;
    in_word_t  in_data_reg;
    logic      out_valid_reg;
    out_word_t out_data_reg;
    logic      adv;
    logic      res_valid;
    out_word_t res_word;

    assign adv     = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || adv;
    assign m_valid = out_valid_reg;
    assign m_data  = out_data_reg;

    efd_core u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .step      (adv),
        .in_word   (in_data_reg),
        .res_valid (res_valid),
        .res_word  (res_word)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (s_ready) begin
                in_valid_reg <= s_valid;
            end
            if (adv) begin
                out_valid_reg <= res_valid;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_data_reg <= s_data;
        end
        if (adv && res_valid) begin
            out_data_reg <= res_word;
        end
    end

endmodule

// ===== design/efd_core.sv =====
// Frame state machine: preamble hunt, header capture, CRC and FCS window, summary.
module efd_core
    import efd_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      step,
    input  in_word_t  in_word,
    output logic      res_valid,
    output out_word_t res_word
);

    state_t      state_reg, state_next;
    logic [2:0]  pre_run_reg, pre_run_next;
    logic [4:0]  hdr_idx_reg, hdr_idx_next;
    logic [47:0] dest_reg, dest_next;
    logic [47:0] source_reg, source_next;
    logic [15:0] type_reg, type_next;
    logic [31:0] tail_reg, tail_next;
    logic [31:0] crc_reg, crc_next;
    logic [15:0] body_reg, body_next;
    logic [7:0]  frame_cnt_reg, frame_cnt_next;

    logic [7:0]  b;
    logic        last;
    logic        runt;
    logic [31:0] crc_final;

    assign b    = in_word.data_byte;
    assign last = in_word.frame_end;

    always_comb begin
        state_next     = state_reg;
        pre_run_next   = pre_run_reg;
        hdr_idx_next   = hdr_idx_reg;
        dest_next      = dest_reg;
        source_next    = source_reg;
        type_next      = type_reg;
        tail_next      = tail_reg;
        crc_next       = crc_reg;
        body_next      = body_reg;
        frame_cnt_next = frame_cnt_reg;
        res_valid      = 1'b0;
        case (state_reg)
            ST_HUNT: begin
                if (last) begin
                    pre_run_next = 3'd0;
                end else if (b == PRE_BYTE) begin
                    if (pre_run_reg < PRE_MIN) begin
                        pre_run_next = pre_run_reg + 3'd1;
                    end
                end else if (b == SFD_BYTE && pre_run_reg == PRE_MIN) begin
                    state_next     = ST_FRAME;
                    pre_run_next   = 3'd0;
                    frame_cnt_next = frame_cnt_reg + 8'd1;
                    hdr_idx_next   = 5'd0;
                    dest_next      = 48'd0;
                    source_next    = 48'd0;
                    type_next      = 16'd0;
                    tail_next      = 32'd0;
                    crc_next       = CRC_ALL;
                    body_next      = 16'd0;
                end else begin
                    pre_run_next = 3'd0;
                end
            end
            ST_FRAME: begin
                if (hdr_idx_reg < 5'd6) begin
                    dest_next = {dest_reg[39:0], b};
                end else if (hdr_idx_reg < 5'd12) begin
                    source_next = {source_reg[39:0], b};
                end else if (hdr_idx_reg < 5'd14) begin
                    type_next = {type_reg[7:0], b};
                end
                if (hdr_idx_reg >= 5'd4) begin
                    crc_next = crc_byte(crc_reg, tail_reg[7:0]);
                end
                tail_next = {b, tail_reg[31:8]};
                if (hdr_idx_reg >= HDR_LEN) begin
                    if (body_reg < BODY_MAX) begin
                        body_next = body_reg + 16'd1;
                    end
                end else begin
                    hdr_idx_next = hdr_idx_reg + 5'd1;
                end
                if (last) begin
                    res_valid    = 1'b1;
                    state_next   = ST_HUNT;
                    pre_run_next = 3'd0;
                end
            end
            default: begin
                state_next = ST_HUNT;
            end
        endcase
    end

    assign runt      = hdr_idx_next < HDR_LEN;
    assign crc_final = crc_next ^ CRC_ALL;

    always_comb begin
        res_word.dest_address   = dest_next;
        res_word.source_address = source_next;
        res_word.ether_type     = type_next;
        res_word.payload_length = runt ? 16'd0 : body_next;
        res_word.received_fcs   = tail_next;
        res_word.computed_crc   = crc_final;
        res_word.frame_number   = frame_cnt_reg;
        if (runt) begin
            res_word.status = STATUS_RUNT;
        end else if (tail_next == crc_final) begin
            res_word.status = STATUS_OK;
        end else begin
            res_word.status = STATUS_CRC_BAD;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_HUNT;
            pre_run_reg   <= 3'd0;
            hdr_idx_reg   <= 5'd0;
            frame_cnt_reg <= 8'd0;
            body_reg      <= 16'd0;
            crc_reg       <= CRC_ALL;
        end else if (step) begin
            state_reg     <= state_next;
            pre_run_reg   <= pre_run_next;
            hdr_idx_reg   <= hdr_idx_next;
            frame_cnt_reg <= frame_cnt_next;
            body_reg      <= body_next;
            crc_reg       <= crc_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (step) begin
            dest_reg   <= dest_next;
            source_reg <= source_next;
            type_reg   <= type_next;
            tail_reg   <= tail_next;
        end
    end

endmodule

// ===== bench/tb_ethernet_frame_deframer_fcs.sv =====
// Self-checking testbench for the Ethernet deframer with FCS check.
`timescale 1ns / 1ps

module tb_ethernet_frame_deframer_fcs;
    import efd_pkg::*;

    localparam int QUIET_LIMIT = 1000;
    localparam int DRAIN_CYCLES = 8;
    localparam int WORD_BUDGET = 800;

    typedef enum {FILL_RANDOM, FILL_ZERO, FILL_ONE} fill_t;

    logic      aclk = 1'b0;
    logic      aresetn;
    logic      s_valid;
    logic      s_ready;
    in_word_t  s_data;
    logic      m_valid;
    logic      m_ready;
    out_word_t m_data;

    ethernet_frame_deframer_fcs DUT (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    always #6 aclk = ~aclk;

    logic        mdl_hunting;
    logic [2:0]  mdl_pre_run;
    logic [4:0]  mdl_hdr_idx;
    logic [47:0] mdl_dest;
    logic [47:0] mdl_source;
    logic [15:0] mdl_type;
    logic [31:0] mdl_tail;
    logic [31:0] mdl_crc;
    logic [15:0] mdl_body;
    logic [7:0]  mdl_frames;

    out_word_t  expected_summaries[$];
    out_word_t  want_summary;
    logic [7:0] frame_buf[];

    int   errors = 0;
    int   words_sent = 0;
    int   frames_shipped = 0;
    int   summaries_checked = 0;
    int   ok_seen = 0;
    int   bad_seen = 0;
    int   runt_seen = 0;
    int   quiet_cycles = 0;
    int   burst_left = 0;
    bit   steady = 1'b0;
    logic [7:0] stall_pattern = 8'hFF;
    int   stall_timer = 0;

    function automatic logic [31:0] crc32_next(input logic [31:0] acc, input logic [7:0] d);
        logic [31:0] r;
        r = acc;
        for (int i = 0; i < 8; i++) begin
            if (r[0] ^ d[i]) begin
                r = (r >> 1) ^ CRC_POLY;
            end else begin
                r = r >> 1;
            end
        end
        return r;
    endfunction

    function automatic void predict_deframe(input in_word_t w);
        logic [7:0] b;
        out_word_t  s;
        b = w.data_byte;
        if (mdl_hunting) begin
            if (w.frame_end) begin
                mdl_pre_run = '0;
            end else if (b == PRE_BYTE) begin
                if (mdl_pre_run < PRE_MIN) mdl_pre_run = mdl_pre_run + 3'd1;
            end else if (b == SFD_BYTE && mdl_pre_run == PRE_MIN) begin
                mdl_hunting = 1'b0;
                mdl_pre_run = '0;
                mdl_frames  = mdl_frames + 8'd1;
                mdl_hdr_idx = '0;
                mdl_dest    = '0;
                mdl_source  = '0;
                mdl_type    = '0;
                mdl_tail    = '0;
                mdl_crc     = CRC_ALL;
                mdl_body    = '0;
            end else begin
                mdl_pre_run = '0;
            end
            return;
        end
        if (mdl_hdr_idx < 6) begin
            mdl_dest = {mdl_dest[39:0], b};
        end else if (mdl_hdr_idx < 12) begin
            mdl_source = {mdl_source[39:0], b};
        end else if (mdl_hdr_idx < 14) begin
            mdl_type = {mdl_type[7:0], b};
        end
        if (mdl_hdr_idx >= 4) mdl_crc = crc32_next(mdl_crc, mdl_tail[7:0]);
        mdl_tail = {b, mdl_tail[31:8]};
        if (mdl_hdr_idx >= HDR_LEN) begin
            if (mdl_body != BODY_MAX) mdl_body = mdl_body + 16'd1;
        end else begin
            mdl_hdr_idx = mdl_hdr_idx + 5'd1;
        end
        if (!w.frame_end) return;
        s.dest_address   = mdl_dest;
        s.source_address = mdl_source;
        s.ether_type     = mdl_type;
        s.received_fcs   = mdl_tail;
        s.computed_crc   = ~mdl_crc;
        s.frame_number   = mdl_frames;
        if (mdl_hdr_idx < HDR_LEN) begin
            s.payload_length = '0;
            s.status         = STATUS_RUNT;
        end else begin
            s.payload_length = mdl_body;
            s.status         = (mdl_tail == ~mdl_crc) ? STATUS_OK : STATUS_CRC_BAD;
        end
        expected_summaries.insert(expected_summaries.size(), s);
        mdl_hunting = 1'b1;
        mdl_pre_run = '0;
    endfunction

    task automatic check_field(input string name, input logic [63:0] want, input logic [63:0] got);
        if (want !== got) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            errors++;
        end
    endtask

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (expected_summaries.size() == 0) begin
                $error("summary word arrived with none expected");
                errors++;
            end else begin
                want_summary = expected_summaries.pop_front();
                check_field("dest_address", 64'(want_summary.dest_address),
                            64'(m_data.dest_address));
                check_field("source_address", 64'(want_summary.source_address),
                            64'(m_data.source_address));
                check_field("ether_type", 64'(want_summary.ether_type),
                            64'(m_data.ether_type));
                check_field("payload_length", 64'(want_summary.payload_length),
                            64'(m_data.payload_length));
                check_field("received_fcs", 64'(want_summary.received_fcs),
                            64'(m_data.received_fcs));
                check_field("computed_crc", 64'(want_summary.computed_crc),
                            64'(m_data.computed_crc));
                check_field("frame_number", 64'(want_summary.frame_number),
                            64'(m_data.frame_number));
                check_field("status", 64'(want_summary.status), 64'(m_data.status));
                summaries_checked++;
                if (want_summary.status == STATUS_OK) ok_seen++;
                else if (want_summary.status == STATUS_CRC_BAD) bad_seen++;
                else runt_seen++;
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            m_ready <= stall_pattern[0];
            if (stall_timer == 0) begin
                stall_pattern <= ($urandom_range(0, 3) == 0) ? 8'hFF : (8'($urandom) | 8'h01);
                stall_timer <= $urandom_range(16, 96);
            end else begin
                stall_pattern <= {stall_pattern[0], stall_pattern[7:1]};
                stall_timer <= stall_timer - 1;
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles == QUIET_LIMIT) begin
            $display("ethernet_frame_deframer_fcs: mismatch");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic pause_sender(input int cycles);
        s_valid <= 1'b0;
        s_data  <= in_word_t'($urandom);
        repeat (cycles) @(posedge aclk);
    endtask

    task automatic drain_summaries();
        s_valid <= 1'b0;
        do @(posedge aclk); while (expected_summaries.size() != 0);
    endtask

    task automatic send_word(input logic [7:0] b, input logic fe);
        in_word_t w;
        if (!steady && burst_left == 0) begin
            pause_sender($urandom_range(1, 10));
            burst_left = $urandom_range(1, 24);
        end
        if (burst_left > 0) burst_left--;
        w.data_byte = b;
        w.frame_end = fe;
        s_valid <= 1'b1;
        s_data  <= w;
        do @(posedge aclk); while (!(s_valid && s_ready));
        predict_deframe(w);
        words_sent++;
    endtask

    task automatic fill_frame(input int len, input fill_t mode);
        frame_buf = new[len];
        for (int i = 0; i < len; i++) begin
            case (mode)
                FILL_ZERO: frame_buf[i] = 8'h00;
                FILL_ONE:  frame_buf[i] = 8'hFF;
                default:   frame_buf[i] = 8'($urandom);
            endcase
        end
    endtask

    task automatic ship_frame(input int pre_len, input bit good_fcs);
        logic [31:0] acc;
        int          n;
        n = frame_buf.size();
        if (good_fcs && n >= 4) begin
            acc = CRC_ALL;
            for (int i = 0; i < n - 4; i++) acc = crc32_next(acc, frame_buf[i]);
            acc = ~acc;
            for (int k = 0; k < 4; k++) frame_buf[n - 4 + k] = acc[8*k +: 8];
        end
        repeat (pre_len) send_word(PRE_BYTE, 1'b0);
        send_word(SFD_BYTE, 1'b0);
        for (int i = 0; i < n; i++) send_word(frame_buf[i], i == n - 1);
        frames_shipped++;
    endtask

    task automatic test_status_cases();
        fill_frame(18, FILL_ZERO);   ship_frame(7, 1'b1);
        fill_frame(18, FILL_ONE);    ship_frame(7, 1'b0);
        fill_frame(18, FILL_ZERO);   ship_frame(7, 1'b0);
        fill_frame(64, FILL_RANDOM); ship_frame(8, 1'b1);
        fill_frame(64, FILL_RANDOM); ship_frame(7, 1'b0);
        fill_frame(22, FILL_ONE);    ship_frame(7, 1'b1);
    endtask

    task automatic test_preamble_cases();
        fill_frame(20, FILL_RANDOM); ship_frame(15, 1'b1);
        repeat (4) send_word(PRE_BYTE, 1'b0);
        send_word(8'h55, 1'b0);
        fill_frame(18, FILL_RANDOM); ship_frame(7, 1'b1);
        repeat (6) send_word(PRE_BYTE, 1'b0);
        send_word(SFD_BYTE, 1'b0);
        send_word(8'h00, 1'b0);
        repeat (7) send_word(PRE_BYTE, 1'b0);
        send_word(SFD_BYTE, 1'b1);
        repeat (7) send_word(PRE_BYTE, 1'b0);
        send_word(PRE_BYTE, 1'b1);
        send_word(SFD_BYTE, 1'b0);
        send_word(SFD_BYTE, 1'b0);
        fill_frame(19, FILL_RANDOM); ship_frame(9, 1'b1);
    endtask

    task automatic test_runt_frames();
        for (int len = 1; len < HDR_LEN; len++) begin
            fill_frame(len, FILL_RANDOM);
            ship_frame(7, 1'($urandom_range(0, 1)));
        end
    endtask

    task automatic test_random_traffic();
        int choice;
        while (words_sent < WORD_BUDGET) begin
            choice = $urandom_range(0, 9);
            if ($urandom_range(0, 7) == 0) steady = ~steady;
            if (choice == 0) begin
                repeat ($urandom_range(1, 6)) send_word(8'($urandom), $urandom_range(0, 7) == 0);
            end else if (choice == 1) begin
                repeat ($urandom_range(1, 6)) send_word(PRE_BYTE, 1'b0);
                send_word(SFD_BYTE, 1'($urandom_range(0, 1)));
            end else if (choice == 2) begin
                fill_frame($urandom_range(1, HDR_LEN - 1), FILL_RANDOM);
                ship_frame($urandom_range(7, 10), 1'($urandom_range(0, 1)));
            end else begin
                if ($urandom_range(0, 9) == 0) fill_frame($urandom_range(61, 120), FILL_RANDOM);
                else fill_frame($urandom_range(HDR_LEN, 60), FILL_RANDOM);
                ship_frame($urandom_range(7, 10), $urandom_range(0, 4) != 0);
            end
            if ($urandom_range(0, 15) == 0) drain_summaries();
        end
        steady = 1'b0;
    endtask

    initial begin
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_data  = '0;
        mdl_hunting = 1'b1;
        mdl_pre_run = '0;
        mdl_hdr_idx = '0;
        mdl_dest    = '0;
        mdl_source  = '0;
        mdl_type    = '0;
        mdl_tail    = '0;
        mdl_crc     = CRC_ALL;
        mdl_body    = '0;
        mdl_frames  = '0;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        test_status_cases();
        drain_summaries();
        test_preamble_cases();
        test_runt_frames();
        drain_summaries();
        test_random_traffic();
        drain_summaries();
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("Sent %0d byte words in %0d frames, with preamble, runt and FCS status cases.",
                 words_sent, frames_shipped);
        $display("Checked %0d summaries: %0d FCS good, %0d FCS bad, %0d runt.",
                 summaries_checked, ok_seen, bad_seen, runt_seen);
        if (errors == 0) begin
            $display("ethernet_frame_deframer_fcs: match");
        end else begin
            $display("ethernet_frame_deframer_fcs: mismatch");
        end
        $finish;
    end

endmodule
